>>> sv/tts_pkg.sv
// Shared types, constants and tables for the tone track sequencer.
package tts_pkg;

  // Track table geometry
  localparam int TRACK_DEPTH = 256;
  localparam int PosW        = $clog2(TRACK_DEPTH);
  localparam int LenW        = 9;

  // Item opcodes
  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // Register index decoded from paddr
  localparam logic REG_TRACK_LENGTH = 1'b0;

  // Fixed values of the behavior
  localparam logic [15:0] MS_PER_MINUTE    = 16'd60000;
  localparam logic [15:0] BEAT_ZERO_BPM_MS = 16'd100;
  localparam logic [15:0] BEAT_RESET_MS    = 16'd1000;
  localparam logic [15:0] TONE_DEFAULT_HZ  = 16'd2000;
  localparam logic [6:0]  DUTY_DEFAULT_PCT = 7'd50;

  // Divide by 100 as multiply by ceil(2^37/100), then shift right by 37;
  // exact for every dividend below 2^31
  localparam logic [31:0] PCT_RECIP = 32'd1374389535;
  localparam int          PCT_SHIFT = 37;

  // Divider geometry
  localparam int DivW    = 32;
  localparam int DivCntW = $clog2(DivW);

  // Fifteenths to truncated percent
  localparam logic [6:0] PCT15 [16] = '{
    7'd0,  7'd6,  7'd13, 7'd20, 7'd26, 7'd33, 7'd40,  7'd46,
    7'd53, 7'd60, 7'd66, 7'd73, 7'd80, 7'd86, 7'd93, 7'd100
  };

  typedef struct packed {
    logic        opcode;
    logic [7:0]  tick_ms;
    logic [7:0]  entry_index;
    logic        entry_is_tempo;
    logic [15:0] entry_pitch;
    logic [7:0]  entry_beats;
    logic [3:0]  entry_on_ratio;
    logic [3:0]  entry_duty;
  } in_item_t;

  typedef struct packed {
    logic [15:0] tone_hz;
    logic [6:0]  duty_pct;
    logic [7:0]  track_position;
  } out_item_t;

  typedef struct packed {
    logic        is_tempo;
    logic [15:0] pitch;
    logic [7:0]  beats;
    logic [3:0]  on_ratio;
    logic [3:0]  duty;
  } entry_t;

  // Controller to datapath
  typedef struct packed {
    logic wr_entry;
    logic set_defaults;
    logic tick_begin;
    logic mem_rd;
    logic tempo_step;
    logic silence;
    logic mul_n;
    logic mul_g;
    logic div_start;
    logic ld_gate;
    logic play;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic short_track;
    logic is_tempo;
    logic bpm_zero;
    logic pending;
    logic last_scan;
    logic div_done;
  } status_t;

endpackage

>>> sv/tts_div.sv
// Restoring divider, one quotient bit per cycle.
module tts_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [tts_pkg::DivW-1:0]   dividend_i,
  input  logic [15:0]                divisor_i,
  output logic                       done_o,
  output logic [tts_pkg::DivW-1:0]   quotient_o
);

  logic                         run_q;
  logic                         done_q;
  logic [tts_pkg::DivCntW-1:0]  cnt_q;
  logic [tts_pkg::DivW-1:0]     dvd_q;
  logic [15:0]                  dvs_q;
  logic [15:0]                  rem_q;
  logic [16:0]                  shifted;
  logic [16:0]                  diff;
  logic                         ge;

  assign shifted = {rem_q, dvd_q[tts_pkg::DivW-1]};
  assign ge      = shifted >= {1'b0, dvs_q};
  assign diff    = shifted - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == tts_pkg::DivCntW'(tts_pkg::DivW - 1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      dvs_q <= divisor_i;
      rem_q <= '0;
    end else if (run_q) begin
      dvd_q <= {dvd_q[tts_pkg::DivW-2:0], ge};
      rem_q <= ge ? diff[15:0] : shifted[15:0];
    end
  end

  assign done_o     = done_q;
  assign quotient_o = dvd_q;

endmodule

>>> sv/tts_ctrl.sv
// Sequencing state machine for tone track ticks and table writes.
module tts_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic             opcode_i,
  input  tts_pkg::status_t status_i,
  output tts_pkg::cmd_t    cmd_o,
  output logic             busy_o,
  output logic             done_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_READ = 3'd1;
  localparam logic [2:0] S_EVAL = 3'd2;
  localparam logic [2:0] S_DIVB = 3'd3;
  localparam logic [2:0] S_MULG = 3'd4;
  localparam logic [2:0] S_GATE = 3'd5;
  localparam logic [2:0] S_PLAY = 3'd6;

  logic [2:0] state_q, state_d;
  logic       done_q, done_d;

  always_comb begin
    state_d = state_q;
    done_d  = 1'b0;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          if (opcode_i == tts_pkg::OP_WRITE) begin
            cmd_o.wr_entry = 1'b1;
            done_d         = 1'b1;
          end else if (status_i.short_track) begin
            cmd_o.set_defaults = 1'b1;
            done_d             = 1'b1;
          end else begin
            cmd_o.tick_begin = 1'b1;
            state_d          = S_READ;
          end
        end
      end
      S_READ: begin
        cmd_o.mem_rd = 1'b1;
        state_d      = S_EVAL;
      end
      S_EVAL: begin
        if (status_i.is_tempo) begin
          if (status_i.bpm_zero) begin
            cmd_o.tempo_step = 1'b1;
            if (status_i.last_scan) begin
              cmd_o.silence = 1'b1;
              done_d        = 1'b1;
              state_d       = S_IDLE;
            end else begin
              state_d = S_READ;
            end
          end else begin
            cmd_o.div_start = 1'b1;
            state_d         = S_DIVB;
          end
        end else if (status_i.pending) begin
          cmd_o.mul_n = 1'b1;
          state_d     = S_MULG;
        end else begin
          state_d = S_PLAY;
        end
      end
      S_DIVB: begin
        if (status_i.div_done) begin
          cmd_o.tempo_step = 1'b1;
          if (status_i.last_scan) begin
            cmd_o.silence = 1'b1;
            done_d        = 1'b1;
            state_d       = S_IDLE;
          end else begin
            state_d = S_READ;
          end
        end
      end
      S_MULG: begin
        cmd_o.mul_g = 1'b1;
        state_d     = S_GATE;
      end
      S_GATE: begin
        cmd_o.ld_gate = 1'b1;
        state_d       = S_PLAY;
      end
      S_PLAY: begin
        cmd_o.play = 1'b1;
        done_d     = 1'b1;
        state_d    = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  assign busy_o = state_q != S_IDLE;
  assign done_o = done_q;

endmodule

>>> sv/tts_datapath.sv
// Track table, playback registers and arithmetic of the tone track sequencer.
module tts_datapath (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  tts_pkg::cmd_t              cmd_i,
  input  tts_pkg::in_item_t          item_i,
  input  logic [tts_pkg::LenW-1:0]   track_length_i,
  output tts_pkg::status_t           status_o,
  output tts_pkg::out_item_t         result_o
);

  tts_pkg::entry_t mem [tts_pkg::TRACK_DEPTH];
  tts_pkg::entry_t rd_q;

  logic [tts_pkg::LenW-1:0] len;
  logic [tts_pkg::LenW-1:0] pos_inc;
  logic [tts_pkg::PosW-1:0] pos_next;

  logic [15:0]               beat_q;
  logic [tts_pkg::PosW-1:0]  pos_q;
  logic signed [24:0]        note_q;
  logic signed [24:0]        gate_q;
  logic                      pend_q;
  logic [15:0]               tone_q;
  logic [6:0]                duty_q;
  logic [7:0]                ms_q;
  logic [tts_pkg::LenW-1:0]  g_q;
  logic [23:0]               n_q;
  logic [30:0]               prod_q;
  logic [62:0]               gate_prod;

  logic signed [24:0]        note_new;
  logic signed [24:0]        gate_new;

  logic [tts_pkg::DivW-1:0]  div_dividend;
  logic [15:0]               div_divisor;
  logic                      div_done;
  logic [tts_pkg::DivW-1:0]  div_quo;

  // Clamp the configured length to the table depth
  assign len = (track_length_i > tts_pkg::LenW'(tts_pkg::TRACK_DEPTH))
             ? tts_pkg::LenW'(tts_pkg::TRACK_DEPTH) : track_length_i;

  assign pos_inc  = tts_pkg::LenW'(pos_q) + 1'b1;
  assign pos_next = (pos_inc == len) ? '0 : pos_inc[tts_pkg::PosW-1:0];

  assign note_new = note_q - $signed({17'd0, ms_q});
  assign gate_new = gate_q - $signed({17'd0, ms_q});

  // Gate length: length * on percent / 100 by reciprocal multiplication
  assign gate_prod = {32'd0, prod_q} * {31'd0, tts_pkg::PCT_RECIP};

  assign div_dividend = tts_pkg::DivW'(tts_pkg::MS_PER_MINUTE);
  assign div_divisor  = rd_q.pitch;

  tts_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // Track table: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_entry &&
        (tts_pkg::LenW'(item_i.entry_index) < tts_pkg::LenW'(tts_pkg::TRACK_DEPTH))) begin
      mem[item_i.entry_index[tts_pkg::PosW-1:0]] <= '{
        is_tempo: item_i.entry_is_tempo,
        pitch:    item_i.entry_pitch,
        beats:    item_i.entry_beats,
        on_ratio: item_i.entry_on_ratio,
        duty:     item_i.entry_duty
      };
    end
    if (cmd_i.mem_rd) begin
      rd_q <= mem[pos_q];
    end
  end

  // Working values of one tick
  always_ff @(posedge clk_i) begin
    if (cmd_i.tick_begin) begin
      ms_q <= item_i.tick_ms;
    end
    if (cmd_i.mul_n) begin
      n_q <= (rd_q.beats == 8'd0) ? 24'd1 : 24'(rd_q.beats) * 24'(beat_q);
    end
    if (cmd_i.mul_g) begin
      prod_q <= 31'(n_q) * 31'(tts_pkg::PCT15[rd_q.on_ratio]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beat_q <= tts_pkg::BEAT_RESET_MS;
      pos_q  <= '0;
      note_q <= '0;
      gate_q <= '0;
      pend_q <= 1'b1;
      tone_q <= tts_pkg::TONE_DEFAULT_HZ;
      duty_q <= tts_pkg::DUTY_DEFAULT_PCT;
      g_q    <= '0;
    end else begin
      if (cmd_i.set_defaults) begin
        beat_q <= tts_pkg::BEAT_RESET_MS;
        pos_q  <= '0;
        note_q <= '0;
        gate_q <= '0;
        tone_q <= tts_pkg::TONE_DEFAULT_HZ;
        duty_q <= tts_pkg::DUTY_DEFAULT_PCT;
      end
      if (cmd_i.tick_begin) begin
        g_q <= '0;
        if (tts_pkg::LenW'(pos_q) >= len) begin
          pos_q <= '0;
        end
      end
      if (cmd_i.tempo_step) begin
        beat_q <= (rd_q.pitch == 16'd0) ? tts_pkg::BEAT_ZERO_BPM_MS : div_quo[15:0];
        pend_q <= 1'b1;
        note_q <= '0;
        pos_q  <= pos_next;
        g_q    <= g_q + 1'b1;
      end
      // silence always comes with the last tempo step, which clears the note time
      if (cmd_i.silence) begin
        tone_q <= '0;
        duty_q <= '0;
        gate_q <= '0;
      end
      if (cmd_i.mul_g) begin
        note_q <= $signed({1'b0, n_q});
      end
      if (cmd_i.ld_gate) begin
        gate_q <= $signed({1'b0, gate_prod[tts_pkg::PCT_SHIFT +: 24]});
        pend_q <= 1'b0;
      end
      if (cmd_i.play) begin
        tone_q <= rd_q.pitch;
        duty_q <= (gate_q > 25'sd0) ? tts_pkg::PCT15[rd_q.duty] : 7'd0;
        if (note_new <= 25'sd0) begin
          pend_q <= 1'b1;
          note_q <= '0;
          gate_q <= '0;
          pos_q  <= pos_next;
        end else begin
          note_q <= note_new;
          gate_q <= gate_new;
        end
      end
    end
  end

  assign status_o.short_track = len <= tts_pkg::LenW'(1);
  assign status_o.is_tempo    = rd_q.is_tempo;
  assign status_o.bpm_zero    = rd_q.pitch == 16'd0;
  assign status_o.pending     = pend_q;
  assign status_o.last_scan   = (g_q + 1'b1) == len;
  assign status_o.div_done    = div_done;

  assign result_o.tone_hz        = tone_q;
  assign result_o.duty_pct       = duty_q;
  assign result_o.track_position = 8'(pos_q);

endmodule

>>> sv/tone_track_sequencer.sv
// Top level of the tone track sequencer: register port, controller and datapath.
//
// Buzzer tune sequencer. A write item (opcode 1) stores one entry in the
// 256-entry track table; a tick item (opcode 0) advances playback by tick_ms
// milliseconds. Each accepted item gives exactly one result, shown on
// result_o for a single cycle while done_o is high; the receiver cannot
// stall, so sample it then. Items are taken one at a time: start is accepted
// only while busy is low. A write or a tick on a track of one entry or less
// gives its result in the next cycle, and the next item can be accepted
// there. A tick that reaches a note reads the entry, evaluates it and plays
// it; when a new note starts, two multiplies set the note and gate lengths
// before it plays. Each tempo entry skipped adds another read and
// evaluation, plus a run of the 32-step divider for the beat period when its
// bpm is nonzero. The table has one registered read port, which paces the
// scan. The table is not cleared at reset: write every entry in use before
// ticking.
// Write track_length (byte address 0) only while busy is low.
module tone_track_sequencer (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // Item channel
  input  logic                   start,
  output logic                   busy,
  input  tts_pkg::in_item_t      in_item_i,
  output logic                   done_o,
  output tts_pkg::out_item_t     result_o,
  // Register port
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [2:0]             paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  logic [tts_pkg::LenW-1:0] track_length_q;
  logic                     reg_wr;
  logic                     reg_hit;
  tts_pkg::cmd_t            cmd;
  tts_pkg::status_t         status;

  // Register port: zero wait states, one register at word 0
  assign pready  = 1'b1;
  assign reg_hit = paddr[2] == tts_pkg::REG_TRACK_LENGTH;
  assign reg_wr  = psel && penable && pwrite && pready;
  assign prdata  = reg_hit ? 32'(track_length_q) : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      track_length_q <= '0;
    end else if (reg_wr && reg_hit) begin
      // keep the low nine bits; writes to other words drop
      track_length_q <= pwdata[tts_pkg::LenW-1:0];
    end
  end

  // Controller steps through table scan, note setup and playback
  tts_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .opcode_i (in_item_i.opcode),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy),
    .done_o   (done_o)
  );

  // Datapath holds the table, playback state and the divider;
  // its state registers drive the result directly and hold while idle
  tts_datapath u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .item_i         (in_item_i),
    .track_length_i (track_length_q),
    .status_o       (status),
    .result_o       (result_o)
  );

endmodule
